// ----- hw/rtl/ccc_pkg.sv -----
// ccc_pkg: shared types and constants of the cc/cv charge controller
`timescale 1ns / 1ps

package ccc_pkg;

    // configuration port geometry
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned RES_SLOTS  = 3;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MIN_CURRENT      = 3'd0,
        REG_HEARTBEAT_PERIOD = 3'd1,
        REG_STATUS_PERIOD    = 3'd2,
        REG_RECEIVE_TIMEOUT  = 3'd3,
        REG_COMMAND_ID       = 3'd4,
        REG_HEARTBEAT_ID     = 3'd5,
        REG_STATUS_ID        = 3'd6
    } t_reg_idx;

    // register reset values
    localparam logic [15:0] RST_MIN_CURRENT      = 16'd1;
    localparam logic [15:0] RST_HEARTBEAT_PERIOD = 16'd1000;
    localparam logic [15:0] RST_STATUS_PERIOD    = 16'd200;
    localparam logic [15:0] RST_RECEIVE_TIMEOUT  = 16'd5000;
    localparam logic [10:0] RST_COMMAND_ID       = 11'h201;
    localparam logic [10:0] RST_HEARTBEAT_ID     = 11'h701;
    localparam logic [10:0] RST_STATUS_ID        = 11'h000;

    // input operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // charge modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CC   = 2'd1,
        MODE_CV   = 2'd2
    } t_mode;

    // network states
    localparam logic [1:0] NET_INIT  = 2'd0;
    localparam logic [1:0] NET_PREOP = 2'd1;
    localparam logic [1:0] NET_OP    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DRIVE     = 2'd0;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;

    // drive codes
    localparam logic [1:0] DRIVE_HOLD = 2'd0;
    localparam logic [1:0] DRIVE_INC  = 2'd1;
    localparam logic [1:0] DRIVE_DEC  = 2'd2;

    // frame contents
    localparam logic [7:0] CMD_START        = 8'd1;
    localparam logic [2:0] HEARTBEAT_LENGTH = 3'd1;
    localparam logic [2:0] STATUS_LENGTH    = 3'd5;

    // divide by ten: multiply by a reciprocal, exact for 16-bit operands
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic [15:0] min_current;
        logic [15:0] heartbeat_period;
        logic [15:0] status_period;
        logic [15:0] receive_timeout;
        logic [10:0] command_id;
        logic [10:0] heartbeat_id;
        logic [10:0] status_id;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic [15:0] voltage_sample;
        logic [15:0] current_sample;
        logic [10:0] rx_id;
        logic [7:0]  rx_byte0;
        logic [7:0]  rx_byte1;
        logic [7:0]  rx_byte2;
        logic [7:0]  rx_byte3;
        logic [7:0]  rx_byte4;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  drive;
        logic [1:0]  mode;
        logic [10:0] tx_id;
        logic [2:0]  tx_length;
        logic [7:0]  tx_byte0;
        logic [7:0]  tx_byte1;
        logic [7:0]  tx_byte2;
        logic [7:0]  tx_byte3;
        logic        tx_byte4;
        logic        last;
    } t_out_item;

    // load request from the control core to the result queue
    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } t_res_load;

endpackage

// ----- hw/rtl/ccc_regs.sv -----
// ccc_regs: configuration registers behind the apb-style port
`timescale 1ns / 1ps

module ccc_regs
    import ccc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_current      <= RST_MIN_CURRENT;
            r_cfg.heartbeat_period <= RST_HEARTBEAT_PERIOD;
            r_cfg.status_period    <= RST_STATUS_PERIOD;
            r_cfg.receive_timeout  <= RST_RECEIVE_TIMEOUT;
            r_cfg.command_id       <= RST_COMMAND_ID;
            r_cfg.heartbeat_id     <= RST_HEARTBEAT_ID;
            r_cfg.status_id        <= RST_STATUS_ID;
        end else if (wr_en) begin
            unique case (idx)
                REG_MIN_CURRENT:      r_cfg.min_current      <= pwdata[15:0];
                REG_HEARTBEAT_PERIOD: r_cfg.heartbeat_period <= pwdata[15:0];
                REG_STATUS_PERIOD:    r_cfg.status_period    <= pwdata[15:0];
                REG_RECEIVE_TIMEOUT:  r_cfg.receive_timeout  <= pwdata[15:0];
                REG_COMMAND_ID:       r_cfg.command_id       <= pwdata[10:0];
                REG_HEARTBEAT_ID:     r_cfg.heartbeat_id     <= pwdata[10:0];
                REG_STATUS_ID:        r_cfg.status_id        <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MIN_CURRENT:      prdata = {16'd0, r_cfg.min_current};
            REG_HEARTBEAT_PERIOD: prdata = {16'd0, r_cfg.heartbeat_period};
            REG_STATUS_PERIOD:    prdata = {16'd0, r_cfg.status_period};
            REG_RECEIVE_TIMEOUT:  prdata = {16'd0, r_cfg.receive_timeout};
            REG_COMMAND_ID:       prdata = {21'd0, r_cfg.command_id};
            REG_HEARTBEAT_ID:     prdata = {21'd0, r_cfg.heartbeat_id};
            REG_STATUS_ID:        prdata = {21'd0, r_cfg.status_id};
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ccc_core.sv -----
// ccc_core: charger state and one-pass computation of the results of a transaction
`timescale 1ns / 1ps

module ccc_core
    import ccc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  t_in_item                  i_item,
    input  t_cfg                      i_cfg,
    output t_res_load                 o_res_ld,
    output t_out_item [RES_SLOTS-1:0] o_res
);

    t_mode       r_mode, n_mode;
    logic        r_en, n_en;
    logic [1:0]  r_net, n_net;
    logic [15:0] r_vt, n_vt;
    logic [15:0] r_ct, n_ct;
    logic [15:0] r_sil, n_sil;
    logic [15:0] r_hb, n_hb;
    logic [15:0] r_st, n_st;

    logic [1:0]  drive;
    logic [1:0]  net_hb;
    logic        hb_due;
    logic        st_due;
    logic [15:0] hb_inc;
    logic [15:0] st_inc;
    logic [15:0] sil_inc;
    logic [15:0] sv;
    logic [15:0] sc;
    logic [15:0] v;
    logic [15:0] c;
    logic [15:0] vt_div;
    logic [15:0] ct_div;

    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = {16'd0, x} * DIV10_MUL;
        return {3'd0, p[31:DIV10_SHIFT]};
    endfunction

    function automatic logic [15:0] mul10(input logic [15:0] x);
        return (x << 3) + (x << 1);
    endfunction

    assign v       = i_item.voltage_sample;
    assign c       = i_item.current_sample;
    assign hb_inc  = r_hb + 16'd1;
    assign st_inc  = r_st + 16'd1;
    assign sil_inc = (r_sil == 16'hFFFF) ? r_sil : r_sil + 16'd1;
    assign sv      = mul10(v);
    assign sc      = mul10(c);
    assign vt_div  = div10({i_item.rx_byte0, i_item.rx_byte1});
    assign ct_div  = div10({i_item.rx_byte3, i_item.rx_byte2});

    // next state: a tick runs control, heartbeat, status, then silence timeout; a frame handles commands
    always_comb begin
        n_mode = r_mode;
        n_en   = r_en;
        n_net  = r_net;
        n_vt   = r_vt;
        n_ct   = r_ct;
        n_sil  = r_sil;
        n_hb   = r_hb;
        n_st   = r_st;
        drive  = DRIVE_HOLD;
        net_hb = r_net;
        hb_due = 1'b0;
        st_due = 1'b0;
        if (i_item.operation == OP_TICK) begin
            // cc/cv regulation
            if (r_en) begin
                unique case (r_mode)
                    MODE_CC: begin
                        if (v < r_vt) begin
                            if (c < r_ct) begin
                                drive = DRIVE_INC;
                            end else if (c > r_ct) begin
                                drive = DRIVE_DEC;
                            end
                        end else begin
                            n_mode = MODE_CV;
                        end
                    end
                    MODE_CV: begin
                        if (c > i_cfg.min_current) begin
                            if (v < r_vt) begin
                                drive = DRIVE_INC;
                            end else if (v > r_vt) begin
                                drive = DRIVE_DEC;
                            end
                        end else begin
                            n_mode = MODE_IDLE;
                            n_en   = 1'b0;
                            n_vt   = '0;
                            n_ct   = '0;
                            n_net  = NET_PREOP;
                            n_st   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            net_hb = n_net;
            // heartbeat period
            if (hb_inc >= i_cfg.heartbeat_period) begin
                hb_due = 1'b1;
                n_hb   = '0;
            end else begin
                n_hb = hb_inc;
            end
            // status period, held at zero while idle
            if (n_mode != MODE_IDLE) begin
                if (st_inc >= i_cfg.status_period) begin
                    st_due = 1'b1;
                    n_st   = '0;
                end else begin
                    n_st = st_inc;
                end
            end else begin
                n_st = '0;
            end
            // silence timeout
            n_sil = sil_inc;
            if (sil_inc >= i_cfg.receive_timeout) begin
                n_mode = MODE_IDLE;
                n_en   = 1'b0;
                n_vt   = '0;
                n_ct   = '0;
                n_net  = NET_PREOP;
                n_st   = '0;
            end
        end else begin
            // received frame
            if (i_item.rx_id == i_cfg.command_id) begin
                n_vt = vt_div;
                n_ct = ct_div;
                if (i_item.rx_byte4 == CMD_START) begin
                    if (r_mode == MODE_IDLE) begin
                        n_mode = MODE_CC;
                    end
                    n_net = NET_OP;
                    n_en  = 1'b1;
                end else begin
                    n_mode = MODE_IDLE;
                    n_en   = 1'b0;
                    n_vt   = '0;
                    n_ct   = '0;
                    n_net  = NET_PREOP;
                    n_st   = '0;
                end
            end
            n_sil = '0;
        end
    end

    // result slots in emission order
    always_comb begin
        t_out_item hb_item;
        t_out_item st_item;
        logic [1:0] cnt;
        o_res = '0;
        hb_item = '0;
        st_item = '0;
        hb_item.kind      = KIND_HEARTBEAT;
        hb_item.tx_id     = i_cfg.heartbeat_id;
        hb_item.tx_length = HEARTBEAT_LENGTH;
        hb_item.tx_byte0  = {6'd0, net_hb};
        st_item.kind      = KIND_STATUS;
        st_item.tx_id     = i_cfg.status_id;
        st_item.tx_length = STATUS_LENGTH;
        st_item.tx_byte0  = sv[15:8];
        st_item.tx_byte1  = sv[7:0];
        st_item.tx_byte2  = sc[15:8];
        st_item.tx_byte3  = sc[7:0];
        st_item.tx_byte4  = 1'b1;
        o_res[0].kind  = KIND_DRIVE;
        o_res[0].drive = drive;
        if (hb_due) begin
            o_res[1] = hb_item;
            o_res[2] = st_item;
        end else begin
            o_res[1] = st_item;
        end
        cnt = 2'd1 + {1'b0, hb_due} + {1'b0, st_due};
        for (int i = 0; i < RES_SLOTS; i++) begin
            o_res[i].mode = n_mode;
            o_res[i].last = (cnt == 2'(i + 1));
        end
        o_res_ld.load  = i_load;
        o_res_ld.count = cnt;
    end

    // charger state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_en   <= 1'b0;
            r_net  <= NET_PREOP;
            r_vt   <= '0;
            r_ct   <= '0;
            r_sil  <= '0;
            r_hb   <= '0;
            r_st   <= '0;
        end else if (i_load) begin
            r_mode <= n_mode;
            r_en   <= n_en;
            r_net  <= n_net;
            r_vt   <= n_vt;
            r_ct   <= n_ct;
            r_sil  <= n_sil;
            r_hb   <= n_hb;
            r_st   <= n_st;
        end
    end

    // charging is enabled exactly when a charge mode is active
    a_mode_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) == !r_en)
        else $error("charge mode and enable disagree");

    // idle keeps the status counter and both targets cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_st == 16'd0 && r_vt == 16'd0 && r_ct == 16'd0))
        else $error("idle with status count or targets set");

    // network state is operational exactly while charging
    a_net_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en == (r_net == NET_OP))
        else $error("network state out of step with charging");

endmodule

// ----- hw/rtl/ccc_txq.sv -----
// ccc_txq: result queue that hands out up to three results of a transaction in order
`timescale 1ns / 1ps

module ccc_txq
    import ccc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_res_load                 i_res_ld,
    input  t_out_item [RES_SLOTS-1:0] i_res,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output t_out_item                 o_out_data,
    output logic                      o_free
);

    t_out_item [RES_SLOTS-1:0] r_ent, n_ent;
    logic [1:0]                r_left, n_left;
    logic                      pop;

    assign o_out_valid = (r_left != 2'd0);
    assign o_out_data  = r_ent[0];
    assign pop         = o_out_valid && !i_out_stall;
    assign o_free      = (r_left == 2'd0) || (r_left == 2'd1 && pop);

    // load a new set or shift towards the head
    always_comb begin
        n_ent  = r_ent;
        n_left = r_left;
        if (i_res_ld.load) begin
            n_ent  = i_res;
            n_left = i_res_ld.count;
        end else if (pop) begin
            n_ent[0] = r_ent[1];
            n_ent[1] = r_ent[2];
            n_left   = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left != 2'd3 || !r_ent[0].last)
        else $error("head marked last with results still behind it");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (r_left == 2'd1)))
        else $error("last flag does not match queue fill");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ld.load |-> (r_left == 2'd0 || (r_left == 2'd1 && pop)))
        else $error("result set loaded over pending results");

endmodule

// ----- hw/rtl/cc_cv_charge_controller_top.sv -----
// cc_cv_charge_controller_top: charger supervisor with input register and result queue
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//  config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  an input transaction is registered and worked combinationally into one to three results
//  that are loaded into the result queue; the queue offers them in order, one result per
//  cycle while the output does not stall
//  the queue takes the next item's results as the last result of the previous item leaves
//  synchronous active-low reset returns control state and config registers to defaults
//  a stall on the output holds the queue head; the input stalls only when the
//  input register is full and the queue cannot take its results
`timescale 1ns / 1ps

module cc_cv_charge_controller_top
    import ccc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                      cfg;
    t_in_item                  r_in;
    logic                      r_in_valid;
    logic                      q_free;
    logic                      take;
    logic                      accept;
    t_res_load                 res_ld;
    t_out_item [RES_SLOTS-1:0] res;

    assign take       = r_in_valid && q_free;
    assign o_in_stall = r_in_valid && !q_free;
    assign accept     = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    ccc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ccc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_res_ld (res_ld),
        .o_res    (res)
    );

    ccc_txq u_txq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_ld    (res_ld),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_free      (q_free)
    );

endmodule

// ----- test/tb_cc_cv_charge_controller_top.sv -----
// tb_cc_cv_charge_controller_top: self-checking testbench for the cc/cv charge controller
`timescale 1ns / 1ps

module tb_cc_cv_charge_controller_top;
    import ccc_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    // clock, reset and block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // register copy and charger state as the testbench expects them
    t_cfg        cfg_shadow = '{
        min_current:      RST_MIN_CURRENT,
        heartbeat_period: RST_HEARTBEAT_PERIOD,
        status_period:    RST_STATUS_PERIOD,
        receive_timeout:  RST_RECEIVE_TIMEOUT,
        command_id:       RST_COMMAND_ID,
        heartbeat_id:     RST_HEARTBEAT_ID,
        status_id:        RST_STATUS_ID
    };
    t_mode       chg_mode    = MODE_IDLE;
    logic [1:0]  net_state   = NET_PREOP;
    logic        chg_on      = 1'b0;
    logic [15:0] v_tgt       = '0;
    logic [15:0] c_tgt       = '0;
    logic [15:0] quiet_ticks = '0;
    logic [15:0] hb_ticks    = '0;
    logic [15:0] stat_ticks  = '0;

    t_out_item   charger_outputs_due[$];
    int          fail_count  = 0;

    // stimulus shaping
    int          in_idle_pct  = 11;
    int          out_idle_pct = 11;
    int          aim_v        = 0;
    int          aim_c        = 0;
    int          hold_len     = 0;
    int          hold_seq     = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;

    cc_cv_charge_controller_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    // charging ends: targets cleared, network back to pre-operational
    function automatic void stop_charging();
        chg_mode   = MODE_IDLE;
        chg_on     = 1'b0;
        v_tgt      = '0;
        c_tgt      = '0;
        net_state  = NET_PREOP;
        stat_ticks = '0;
    endfunction

    // expected results of one accepted transaction, state advanced
    function automatic void compute_charger_outputs(input t_in_item it);
        t_out_item   batch[$];
        t_out_item   res;
        logic [1:0]  drv;
        logic [15:0] sv;
        logic [15:0] sc;
        logic [15:0] raw_v;
        logic [15:0] raw_c;
        if (it.operation == OP_TICK) begin
            // control step
            drv = DRIVE_HOLD;
            if (chg_on) begin
                if (chg_mode == MODE_CC) begin
                    if (it.voltage_sample < v_tgt) begin
                        if (it.current_sample < c_tgt) drv = DRIVE_INC;
                        else if (it.current_sample > c_tgt) drv = DRIVE_DEC;
                    end else begin
                        chg_mode = MODE_CV;
                    end
                end else if (chg_mode == MODE_CV) begin
                    if (it.current_sample > cfg_shadow.min_current) begin
                        if (it.voltage_sample < v_tgt) drv = DRIVE_INC;
                        else if (it.voltage_sample > v_tgt) drv = DRIVE_DEC;
                    end else begin
                        stop_charging();
                    end
                end
            end
            res = '0;
            res.kind  = KIND_DRIVE;
            res.drive = drv;
            batch.push_back(res);
            // heartbeat period
            hb_ticks = hb_ticks + 16'd1;
            if (hb_ticks >= cfg_shadow.heartbeat_period) begin
                hb_ticks = '0;
                res = '0;
                res.kind      = KIND_HEARTBEAT;
                res.tx_id     = cfg_shadow.heartbeat_id;
                res.tx_length = HEARTBEAT_LENGTH;
                res.tx_byte0  = {6'd0, net_state};
                batch.push_back(res);
            end
            // status period, only while charging
            if (chg_mode != MODE_IDLE) begin
                stat_ticks = stat_ticks + 16'd1;
                if (stat_ticks >= cfg_shadow.status_period) begin
                    stat_ticks = '0;
                    sv = it.voltage_sample * 16'd10;
                    sc = it.current_sample * 16'd10;
                    res = '0;
                    res.kind      = KIND_STATUS;
                    res.tx_id     = cfg_shadow.status_id;
                    res.tx_length = STATUS_LENGTH;
                    res.tx_byte0  = sv[15:8];
                    res.tx_byte1  = sv[7:0];
                    res.tx_byte2  = sc[15:8];
                    res.tx_byte3  = sc[7:0];
                    res.tx_byte4  = 1'b1;
                    batch.push_back(res);
                end
            end else begin
                stat_ticks = '0;
            end
            // saturating silence counter
            if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
            if (quiet_ticks >= cfg_shadow.receive_timeout) stop_charging();
        end else begin
            // received frame, only the command id acts on the charger
            if (it.rx_id == cfg_shadow.command_id) begin
                raw_v = {it.rx_byte0, it.rx_byte1};
                raw_c = {it.rx_byte3, it.rx_byte2};
                v_tgt = raw_v / 16'd10;
                c_tgt = raw_c / 16'd10;
                if (it.rx_byte4 == CMD_START) begin
                    if (chg_mode == MODE_IDLE) chg_mode = MODE_CC;
                    net_state = NET_OP;
                    chg_on    = 1'b1;
                end else begin
                    stop_charging();
                end
            end
            quiet_ticks = '0;
            res = '0;
            res.kind  = KIND_DRIVE;
            res.drive = DRIVE_HOLD;
            batch.push_back(res);
        end
        foreach (batch[k]) begin
            batch[k].mode = chg_mode;
            batch[k].last = (k == batch.size() - 1);
            charger_outputs_due.push_back(batch[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result check first, then prediction of the transaction accepted at this edge
    always @(posedge i_clk) begin : result_checker
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (charger_outputs_due.size() == 0) begin
                    $error("result kind %0d arrived with no transaction pending",
                           o_out_data.kind);
                    fail_count++;
                end else begin
                    want = charger_outputs_due.pop_front();
                    check_field("kind",      want.kind,      o_out_data.kind);
                    check_field("drive",     want.drive,     o_out_data.drive);
                    check_field("mode",      want.mode,      o_out_data.mode);
                    check_field("tx_id",     want.tx_id,     o_out_data.tx_id);
                    check_field("tx_length", want.tx_length, o_out_data.tx_length);
                    check_field("tx_byte0",  want.tx_byte0,  o_out_data.tx_byte0);
                    check_field("tx_byte1",  want.tx_byte1,  o_out_data.tx_byte1);
                    check_field("tx_byte2",  want.tx_byte2,  o_out_data.tx_byte2);
                    check_field("tx_byte3",  want.tx_byte3,  o_out_data.tx_byte3);
                    check_field("tx_byte4",  want.tx_byte4,  o_out_data.tx_byte4);
                    check_field("last",      want.last,      o_out_data.last);
                end
            end
            if (i_in_valid && !o_in_stall) compute_charger_outputs(i_in_data);
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin : stuck_watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] clip16(input int x);
        if (x < 0) return 16'd0;
        if (x > 65535) return 16'hFFFF;
        return x[15:0];
    endfunction

    // random filler so that unused fields toggle too
    function automatic t_in_item random_item();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return noise[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item build_tick(input logic [15:0] v, input logic [15:0] c);
        t_in_item it;
        it = random_item();
        it.operation      = OP_TICK;
        it.voltage_sample = v;
        it.current_sample = c;
        return it;
    endfunction

    function automatic t_in_item build_frame(input logic [10:0] id, input logic [15:0] raw_v,
                                             input logic [15:0] raw_c, input logic [7:0] cmd);
        t_in_item it;
        it = random_item();
        it.operation = OP_FRAME;
        it.rx_id     = id;
        it.rx_byte0  = raw_v[15:8];
        it.rx_byte1  = raw_v[7:0];
        it.rx_byte2  = raw_c[7:0];
        it.rx_byte3  = raw_c[15:8];
        it.rx_byte4  = cmd;
        return it;
    endfunction

    // mostly start commands on the live id, the rest stops and foreign frames
    function automatic t_in_item make_frame();
        t_in_item it;
        it = random_item();
        it.operation = OP_FRAME;
        if ($urandom_range(99) < 85) it.rx_id = cfg_shadow.command_id;
        if ($urandom_range(99) < 85) it.rx_byte4 = CMD_START;
        if (it.rx_id == cfg_shadow.command_id && it.rx_byte4 == CMD_START) begin
            aim_v = {it.rx_byte0, it.rx_byte1} / 10;
            aim_c = {it.rx_byte3, it.rx_byte2} / 10;
        end
        return it;
    endfunction

    // samples mostly around the targets and the cv cut-off current
    function automatic t_in_item make_tick();
        t_in_item it;
        int       pick;
        it = random_item();
        it.operation = OP_TICK;
        pick = $urandom_range(9);
        if (pick < 5) it.voltage_sample = clip16(aim_v + int'($urandom_range(8)) - 4);
        else if (pick < 7) it.voltage_sample = clip16(int'($urandom_range(aim_v)));
        pick = $urandom_range(9);
        if (pick < 4) it.current_sample = clip16(aim_c + int'($urandom_range(6)) - 3);
        else if (pick < 6)
            it.current_sample = clip16(int'(cfg_shadow.min_current) +
                                       int'($urandom_range(2)) - 1);
        return it;
    endfunction

    // offer one transaction, return at the edge where it is taken
    task automatic send_charger_input(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // let every expected result come out and the block settle
    task automatic wait_outputs_drained();
        i_in_valid <= 1'b0;
        // wait so that the last transaction has been predicted
        @(posedge i_clk);
        while (charger_outputs_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access phase
    task automatic write_register(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_CURRENT:      cfg_shadow.min_current      = value;
            REG_HEARTBEAT_PERIOD: cfg_shadow.heartbeat_period = value;
            REG_STATUS_PERIOD:    cfg_shadow.status_period    = value;
            REG_RECEIVE_TIMEOUT:  cfg_shadow.receive_timeout  = value;
            REG_COMMAND_ID:       cfg_shadow.command_id       = value[10:0];
            REG_HEARTBEAT_ID:     cfg_shadow.heartbeat_id     = value[10:0];
            REG_STATUS_ID:        cfg_shadow.status_id        = value[10:0];
            default: ;
        endcase
    endtask

    task automatic write_all_registers(input logic [15:0] min_i, input logic [15:0] hb_p,
                                       input logic [15:0] st_p, input logic [15:0] tmo,
                                       input logic [10:0] cmd_id, input logic [10:0] hb_id,
                                       input logic [10:0] st_id);
        wait_outputs_drained();
        write_register(REG_MIN_CURRENT, min_i);
        write_register(REG_HEARTBEAT_PERIOD, hb_p);
        write_register(REG_STATUS_PERIOD, st_p);
        write_register(REG_RECEIVE_TIMEOUT, tmo);
        write_register(REG_COMMAND_ID, {5'd0, cmd_id});
        write_register(REG_HEARTBEAT_ID, {5'd0, hb_id});
        write_register(REG_STATUS_ID, {5'd0, st_id});
    endtask

    task automatic run_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 12) send_charger_input(make_frame());
            else send_charger_input(make_tick());
        end
    endtask

    // registers as they come out of reset
    task automatic test_default_registers();
        send_charger_input(build_frame(RST_COMMAND_ID, 16'd1200, 16'd300, CMD_START));
        send_charger_input(build_tick(16'd50, 16'd10));
        send_charger_input(build_tick(16'd50, 16'd40));
        send_charger_input(build_frame(RST_COMMAND_ID, 16'd0, 16'd0, 8'd0));
    endtask

    // every drive decision, mode change and command variant
    task automatic test_control_cases();
        logic [10:0] cmd;
        write_all_registers(16'd100, 16'd4, 16'd3, 16'hFFFF,
                            RST_COMMAND_ID, RST_HEARTBEAT_ID, 11'h155);
        cmd = cfg_shadow.command_id;
        // stop while idle, foreign id, tick while idle
        send_charger_input(build_frame(cmd, 16'd0, 16'd0, 8'd0));
        send_charger_input(build_frame(~cmd, 16'hFFFF, 16'hFFFF, CMD_START));
        send_charger_input(build_tick(16'hFFFF, 16'hFFFF));
        // cc: increase, decrease, hold, then voltage reached
        send_charger_input(build_frame(cmd, 16'd5000, 16'd2000, CMD_START));
        send_charger_input(build_tick(16'd100, 16'd100));
        send_charger_input(build_tick(16'd100, 16'hFFFF));
        send_charger_input(build_tick(16'd100, 16'd200));
        send_charger_input(build_tick(16'hFFFF, 16'd0));
        // cv: increase, decrease, hold
        send_charger_input(build_tick(16'd100, 16'd300));
        send_charger_input(build_tick(16'd600, 16'd300));
        send_charger_input(build_tick(16'd500, 16'd300));
        // restart while charging keeps cv, then current falls to the cut-off
        send_charger_input(build_frame(cmd, 16'hFFFF, 16'hFFFF, CMD_START));
        send_charger_input(build_tick(16'd0, 16'd101));
        send_charger_input(build_tick(16'd0, 16'd100));
        send_charger_input(build_tick(16'd0, 16'd0));
        // stop by other command values
        send_charger_input(build_frame(cmd, 16'd1000, 16'd1000, CMD_START));
        send_charger_input(build_frame(cmd, 16'd1000, 16'd1000, 8'hFF));
        send_charger_input(build_frame(cmd, 16'd1000, 16'd1000, CMD_START));
        send_charger_input(build_tick(16'd0, 16'd0));
        send_charger_input(build_frame(cmd, 16'd1000, 16'd1000, 8'd2));
        send_charger_input(build_tick(16'hFFFF, 16'hFFFF));
    endtask

    // silence timeout stops charging, shortest timeout first
    task automatic test_silence_timeout();
        wait_outputs_drained();
        write_register(REG_RECEIVE_TIMEOUT, 16'd1);
        send_charger_input(build_frame(cfg_shadow.command_id, 16'd3000, 16'd900, CMD_START));
        send_charger_input(build_tick(16'd10, 16'd10));
        send_charger_input(build_tick(16'd10, 16'd10));
        wait_outputs_drained();
        write_register(REG_RECEIVE_TIMEOUT, 16'd3);
        send_charger_input(build_frame(cfg_shadow.command_id, 16'd3000, 16'd900, CMD_START));
        repeat (4) send_charger_input(build_tick(16'd10, 16'd500));
    endtask

    task automatic test_register_extremes();
        write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            11'h7FF, 11'h7FF, 11'h7FF);
        run_random_traffic(40);
        write_all_registers(16'd0, 16'd1, 16'd1, 16'hFFFF, 11'h000, 11'h000, 11'h000);
        run_random_traffic(40);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            write_all_registers(16'($urandom_range(3000)), 16'($urandom_range(9, 1)),
                                16'($urandom_range(9, 1)), 16'($urandom_range(80, 10)),
                                11'($urandom), 11'($urandom), 11'($urandom));
            run_random_traffic(40);
        end
    endtask

    // back-to-back transactions with the receiver always ready
    task automatic test_no_idle_burst();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random_traffic(50);
        in_idle_pct  = 11;
        out_idle_pct = 11;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_hold_off();
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        run_random_traffic(40);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_registers();
        test_control_cases();
        test_silence_timeout();
        test_register_extremes();
        test_random_settings();
        test_no_idle_burst();
        test_output_hold_off();
        wait_outputs_drained();
        if (fail_count == 0 && charger_outputs_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
